// ===== hdl/assert_macros.svh =====
// Assertion helpers included by the controller RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, skipped while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, skipped while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/clpc_pkg.sv =====
package clpc_pkg;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_DATA   = 3'd1,
        OP_CMD    = 3'd2,
        OP_GOTO   = 3'd3,
        OP_CLEAR  = 3'd4,
        OP_NUMBER = 3'd5,
        OP_STRING = 3'd6
    } t_opcode;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_WRITE   = 2'd1,
        KIND_COMMAND = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        JOB_DATA   = 3'd0,
        JOB_NUMBER = 3'd1,
        JOB_STRING = 3'd2,
        JOB_GOTO   = 3'd3,
        JOB_CLEAR  = 3'd4,
        JOB_CMD    = 3'd5
    } t_job;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_PROCESSING = 2'd1,
        ST_BUSY       = 2'd2,
        ST_NONE       = 2'd3
    } t_status;

    typedef enum logic {
        CFG_FUNCTION_SET    = 1'b0,
        CFG_DISPLAY_CONTROL = 1'b1
    } t_cfg_reg;

    localparam logic [2:0] INIT_START        = 3'd0;
    localparam logic [2:0] INIT_FUNCTION_SET = 3'd1;
    localparam logic [2:0] INIT_DISPLAY_CTRL = 3'd2;
    localparam logic [2:0] INIT_CLEAR        = 3'd3;
    localparam logic [2:0] INIT_DONE_STEP    = 3'd5;

    localparam logic [7:0] FUNCTION_SET_RESET = 8'h38;
    localparam logic [7:0] DISPLAY_CTRL_RESET = 8'h0E;
    localparam logic [7:0] CLEAR_CMD          = 8'h01;
    localparam logic [7:0] ENTRY_MODE_CMD     = 8'h06;
    localparam logic [7:0] GOTO_BASE          = 8'h80;
    localparam logic [7:0] ASCII_ZERO         = 8'd48;

    localparam int DEC_DIGITS = 5;

    // j times the decimal weight of digit position k (k = 0 is the units digit)
    function automatic logic [16:0] pow10_times(input logic [2:0] k, input logic [3:0] j);
        logic [16:0] base;
        case (k)
            3'd0:    base = 17'd1;
            3'd1:    base = 17'd10;
            3'd2:    base = 17'd100;
            3'd3:    base = 17'd1000;
            3'd4:    base = 17'd10000;
            default: base = 17'd1;
        endcase
        return 17'(base * {13'd0, j});
    endfunction

endpackage

// ===== hdl/char_lcd_parallel_controller.sv =====
// The result of an input transfer is registered and shows on the output channel in the cycle after it.
// Throughput: one item per cycle while the output is taken; the result register frees in the cycle it is taken.
// A number request peels one decimal digit per bus byte against a table of weights.
// Reset (synchronous, active low): init sequencer at its start step, no request
// pending, bus lines low, config registers at 0x38 and 0x0E; the string buffer
// is not cleared, only its fill count and read index.
module char_lcd_parallel_controller
    import clpc_pkg::*;
#(
    parameter int STRING_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_opcode,
    input  logic [7:0]  i_byte_value,
    input  logic [5:0]  i_column,
    input  logic        i_row,
    input  logic [15:0] i_number_value,
    input  logic        i_last_char,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic        o_reg_select,
    output logic        o_read_write,
    output logic        o_enable_out,
    output logic [7:0]  o_bus_byte,
    output logic        o_init_done,
    output logic        o_idle,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam int CW = $clog2(STRING_DEPTH + 1);
    localparam int AW = (STRING_DEPTH > 1) ? $clog2(STRING_DEPTH) : 1;

    logic          r_out_valid;
    t_status       r_status,    n_status;
    logic [7:0]    r_fs_cmd;
    logic [7:0]    r_dc_cmd;
    logic [2:0]    r_init_step, n_init_step;
    t_kind         r_kind,      n_kind;
    t_job          r_job,       n_job;
    logic          r_enable,    n_enable;
    logic          r_select,    n_select;
    logic [7:0]    r_data,      n_data;
    logic [7:0]    r_pending,   n_pending;
    logic [15:0]   r_num_rem,   n_num_rem;
    logic [2:0]    r_digit_cnt, n_digit_cnt;
    logic [CW-1:0] r_str_len,   n_str_len;
    logic [CW-1:0] r_str_idx,   n_str_idx;
    logic [7:0]    r_str_mem [STRING_DEPTH];
    logic [7:0]    r_str_q;

    logic          in_fire;
    logic          str_wr_en;
    logic [AW-1:0] str_wr_addr;
    logic [AW-1:0] str_rd_addr;
    logic          str_rd_ok;
    logic [2:0]    dig_pos;
    logic [3:0]    dig_val;
    logic [16:0]   dig_sub;
    logic [16:0]   dig_thr;
    logic [CW-1:0] str_idx_inc;
    logic [7:0]    job_byte;
    t_kind         req_kind;
    t_job          req_job;
    logic          req_is_plain;
    t_status       req_status;

    assign in_fire     = i_in_valid && o_in_ready;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_reg_select = r_select;
    assign o_read_write = 1'b0;
    assign o_enable_out = r_enable;
    assign o_bus_byte   = r_data;
    assign o_init_done  = (r_init_step >= INIT_DONE_STEP);
    assign o_idle       = (r_kind == KIND_NONE);

    // Most significant remaining digit: largest j with j * 10^k <= remainder
    assign dig_pos = r_digit_cnt - 3'd1;
    always_comb begin
        dig_val = 4'd0;
        dig_sub = 17'd0;
        dig_thr = 17'd0;
        for (int j = 1; j < 10; j++) begin
            dig_thr = pow10_times(dig_pos, 4'(j));
            if ({1'b0, r_num_rem} >= dig_thr) begin
                dig_val = 4'(j);
                dig_sub = dig_thr;
            end
        end
    end

    assign str_idx_inc = r_str_idx + CW'(1);

    always_comb begin
        case (r_job)
            JOB_NUMBER: job_byte = ASCII_ZERO + {4'd0, dig_val};
            JOB_STRING: job_byte = r_str_q;
            JOB_CLEAR:  job_byte = CLEAR_CMD;
            default:    job_byte = r_pending;
        endcase
    end

    // Kind, job and status of the single-transfer requests
    always_comb begin
        req_is_plain = 1'b1;
        req_kind     = KIND_WRITE;
        req_job      = JOB_DATA;
        case (i_opcode)
            OP_DATA: begin
                req_kind = KIND_WRITE;
                req_job  = JOB_DATA;
            end
            OP_CMD: begin
                req_kind = KIND_COMMAND;
                req_job  = JOB_CMD;
            end
            OP_GOTO: begin
                req_kind = KIND_COMMAND;
                req_job  = JOB_GOTO;
            end
            OP_CLEAR: begin
                req_kind = KIND_COMMAND;
                req_job  = JOB_CLEAR;
            end
            OP_NUMBER: begin
                req_kind = KIND_WRITE;
                req_job  = JOB_NUMBER;
            end
            default: req_is_plain = 1'b0;
        endcase
        if (r_kind == KIND_NONE) begin
            req_status = ST_OK;
        end else if (r_kind == req_kind) begin
            req_status = ST_PROCESSING;
        end else begin
            req_status = ST_BUSY;
        end
    end

    always_comb begin
        n_status    = r_status;
        n_init_step = r_init_step;
        n_kind      = r_kind;
        n_job       = r_job;
        n_enable    = r_enable;
        n_select    = r_select;
        n_data      = r_data;
        n_pending   = r_pending;
        n_num_rem   = r_num_rem;
        n_digit_cnt = r_digit_cnt;
        n_str_len   = r_str_len;
        n_str_idx   = r_str_idx;
        str_wr_en   = 1'b0;

        if (in_fire) begin
            n_status = ST_NONE;
            if (i_opcode == OP_TICK) begin
                if (r_init_step < INIT_DONE_STEP) begin
                    if (r_init_step == INIT_START) begin
                        n_init_step = INIT_FUNCTION_SET;
                    end else if (r_enable) begin
                        n_enable    = 1'b0;
                        n_init_step = r_init_step + 3'd1;
                    end else begin
                        n_select = 1'b0;
                        n_enable = 1'b1;
                        case (r_init_step)
                            INIT_FUNCTION_SET: n_data = r_fs_cmd;
                            INIT_DISPLAY_CTRL: n_data = r_dc_cmd;
                            INIT_CLEAR:        n_data = CLEAR_CMD;
                            default:           n_data = ENTRY_MODE_CMD;
                        endcase
                    end
                end else if (r_kind != KIND_NONE) begin
                    if (r_enable) begin
                        // Falling edge of E: finish or advance the job
                        n_enable = 1'b0;
                        if (r_job == JOB_NUMBER) begin
                            if (r_digit_cnt != 3'd0) begin
                                n_digit_cnt = r_digit_cnt - 3'd1;
                            end
                            if (n_digit_cnt == 3'd0) begin
                                n_kind = KIND_NONE;
                            end
                        end else if (r_job == JOB_STRING) begin
                            n_str_idx = str_idx_inc;
                            if (str_idx_inc >= r_str_len) begin
                                n_str_len = '0;
                                n_str_idx = '0;
                                n_kind    = KIND_NONE;
                            end
                        end else begin
                            n_kind = KIND_NONE;
                        end
                    end else begin
                        n_select = (r_kind == KIND_WRITE);
                        n_data   = job_byte;
                        n_enable = 1'b1;
                        if (r_job == JOB_NUMBER) begin
                            n_num_rem = 16'({1'b0, r_num_rem} - dig_sub);
                        end
                    end
                end
            end else if (i_opcode == OP_STRING) begin
                if (r_kind != KIND_NONE) begin
                    n_status = (r_kind == KIND_WRITE) ? ST_PROCESSING : ST_BUSY;
                end else begin
                    n_status = ST_OK;
                    if (r_str_len < CW'(STRING_DEPTH)) begin
                        str_wr_en = 1'b1;
                        n_str_len = r_str_len + CW'(1);
                    end
                    if (i_last_char) begin
                        n_kind    = KIND_WRITE;
                        n_job     = JOB_STRING;
                        n_str_idx = '0;
                    end
                end
            end else if (req_is_plain) begin
                n_status = req_status;
                if (req_status == ST_OK) begin
                    n_kind = req_kind;
                    n_job  = req_job;
                    case (req_job)
                        JOB_GOTO: n_pending = GOTO_BASE | {1'b0, i_row, i_column};
                        JOB_NUMBER: begin
                            n_num_rem = i_number_value;
                            if (i_number_value >= 16'd10000) begin
                                n_digit_cnt = 3'd5;
                            end else if (i_number_value >= 16'd1000) begin
                                n_digit_cnt = 3'd4;
                            end else if (i_number_value >= 16'd100) begin
                                n_digit_cnt = 3'd3;
                            end else if (i_number_value >= 16'd10) begin
                                n_digit_cnt = 3'd2;
                            end else begin
                                n_digit_cnt = 3'd1;
                            end
                        end
                        JOB_CLEAR: n_pending = r_pending;
                        default:   n_pending = i_byte_value;
                    endcase
                end
            end
        end
    end

    assign str_wr_addr = r_str_len[AW-1:0];
    assign str_rd_addr = n_str_idx[AW-1:0];
    assign str_rd_ok   = (n_str_idx < CW'(STRING_DEPTH));

    // String buffer; the read port follows the next index, write data bypasses
    always_ff @(posedge i_clk) begin
        if (str_wr_en) begin
            r_str_mem[str_wr_addr] <= i_byte_value;
        end
        if (str_wr_en && str_wr_addr == str_rd_addr) begin
            r_str_q <= i_byte_value;
        end else if (str_rd_ok) begin
            r_str_q <= r_str_mem[str_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_fs_cmd    <= FUNCTION_SET_RESET;
            r_dc_cmd    <= DISPLAY_CTRL_RESET;
            r_init_step <= INIT_START;
            r_kind      <= KIND_NONE;
            r_job       <= JOB_DATA;
            r_enable    <= 1'b0;
            r_select    <= 1'b0;
            r_data      <= 8'd0;
            r_pending   <= 8'd0;
            r_digit_cnt <= 3'd0;
            r_str_len   <= '0;
            r_str_idx   <= '0;
        end else begin
            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FUNCTION_SET:    r_fs_cmd <= i_cfg_data;
                    CFG_DISPLAY_CONTROL: r_dc_cmd <= i_cfg_data;
                    default:             r_fs_cmd <= r_fs_cmd;
                endcase
            end
            r_init_step <= n_init_step;
            r_kind      <= n_kind;
            r_job       <= n_job;
            r_enable    <= n_enable;
            r_select    <= n_select;
            r_data      <= n_data;
            r_pending   <= n_pending;
            r_digit_cnt <= n_digit_cnt;
            r_str_len   <= n_str_len;
            r_str_idx   <= n_str_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_num_rem <= n_num_rem;
    end

`include "assert_macros.svh"

    `ASSERT_IMPL(a_stall_only_on_full, i_clk, i_rst_n, !o_in_ready, r_out_valid, "input stalled with empty result register")
    `ASSERT_IMPL(a_str_len_bound, i_clk, i_rst_n, 1'b1, r_str_len <= CW'(STRING_DEPTH), "string fill count beyond buffer depth")
    `ASSERT_IMPL(a_digit_bound, i_clk, i_rst_n, 1'b1, r_digit_cnt <= 3'(DEC_DIGITS), "digit count beyond decimal width")
    `ASSERT_IMPL(a_init_cmd_only, i_clk, i_rst_n, r_init_step < INIT_DONE_STEP, !r_select, "data byte driven during init")
    `ASSERT_NEXT(a_tick_drops_e, i_clk, i_rst_n, in_fire && i_opcode == OP_TICK && r_enable, !r_enable, "tick with E high did not lower E")

endmodule
